>>> rtl/uref_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the UART register frame engine.
// Used by uref_front, uref_fifo, uref_back and uart_register_frame_engine.
package uref_pkg;

  // Request codes on the input side
  typedef enum logic [1:0] {
    REQ_WRITE  = 2'd0,
    REQ_READ   = 2'd1,
    REQ_RXBYTE = 2'd2
  } req_e;

  // Report status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_CHKSUM = 2'd1,
    ST_NACK   = 2'd2,
    ST_UNEXP  = 2'd3
  } status_e;

  // Result item kinds
  typedef enum logic {
    KIND_TX     = 1'b0,
    KIND_REPORT = 1'b1
  } kind_e;

  // Protocol phase kept by the front end
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ACK  = 2'd1,
    PH_READ = 2'd2
  } phase_e;

  // Work handed from front to back
  typedef enum logic [1:0] {
    JOB_WRITE  = 2'd0,
    JOB_READ   = 2'd1,
    JOB_REPORT = 2'd2
  } job_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_FRAME_HEAD   = 2'd0;
  localparam logic [1:0] CFG_ACK_VALUE    = 2'd1;
  localparam logic [1:0] CFG_ADDRESS_MASK = 2'd2;
  localparam logic [1:0] CFG_WRITE_FLAG   = 2'd3;

  // Configuration reset values
  localparam logic [7:0] FRAME_HEAD_RST   = 8'h6A;
  localparam logic [7:0] ACK_VALUE_RST    = 8'h54;
  localparam logic [7:0] ADDRESS_MASK_RST = 8'h7F;
  localparam logic [7:0] WRITE_FLAG_RST   = 8'h80;

  // Data bytes collected in a read before the checksum byte
  localparam logic [1:0] READ_DATA_BYTES = 2'd3;

  // Last item index of each job kind
  localparam logic [2:0] LAST_IDX_WRITE  = 3'd4;
  localparam logic [2:0] LAST_IDX_READ   = 3'd1;
  localparam logic [2:0] LAST_IDX_REPORT = 3'd0;

  typedef struct packed {
    req_e        req_type;
    logic [7:0]  target_addr;
    logic [15:0] write_value;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    kind_e              out_kind;
    logic [7:0]         tx_byte;
    status_e            status;
    logic [23:0]        raw_value;
    logic signed [23:0] signed_value;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] frame_head;
    logic [7:0] ack_value;
    logic [7:0] address_mask;
    logic [7:0] write_flag;
  } cfg_t;

  typedef struct packed {
    job_e            kind;
    logic [4:0][7:0] tx_bytes;
    status_e         status;
    logic [23:0]     raw;
  } job_t;

endpackage

>>> rtl/uref_front.sv
`timescale 1ns / 1ps
// Front end: accepts input transactions, tracks the protocol phase and
// queues jobs for the back end. Depends on uref_pkg.
module uref_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  uref_pkg::in_item_t in_data_i,
  input  uref_pkg::cfg_t   cfg_i,
  input  logic             full_i,
  output logic             push_o,
  output uref_pkg::job_t   job_o
);

  uref_pkg::phase_e phase_q, phase_d;
  logic [1:0]       count_q, count_d;
  logic [7:0]       sum_q, sum_d;
  logic [23:0]      shift_q, shift_d;

  logic       accept;
  logic [7:0] cmd_wr, cmd_rd, wsum, rsum;
  logic       chk_ok;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;

  // Build command bytes and frame sums
  assign cmd_rd = in_data_i.target_addr & cfg_i.address_mask;
  assign cmd_wr = cmd_rd | cfg_i.write_flag;
  assign wsum   = cfg_i.frame_head + cmd_wr + in_data_i.write_value[15:8]
                + in_data_i.write_value[7:0];
  assign rsum   = cfg_i.frame_head + cmd_rd;
  assign chk_ok = (~sum_q) == in_data_i.rx_byte;

  // Next protocol state
  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    sum_d   = sum_q;
    shift_d = shift_q;
    if (accept) begin
      unique case (in_data_i.req_type)
        uref_pkg::REQ_WRITE: begin
          phase_d = uref_pkg::PH_ACK;
          count_d = '0;
          sum_d   = wsum;
          shift_d = '0;
        end
        uref_pkg::REQ_READ: begin
          phase_d = uref_pkg::PH_READ;
          count_d = '0;
          sum_d   = rsum;
          shift_d = '0;
        end
        uref_pkg::REQ_RXBYTE: begin
          unique case (phase_q)
            uref_pkg::PH_ACK: begin
              phase_d = uref_pkg::PH_IDLE;
              count_d = '0;
            end
            uref_pkg::PH_READ: begin
              if (count_q < uref_pkg::READ_DATA_BYTES) begin
                shift_d = {shift_q[15:0], in_data_i.rx_byte};
                sum_d   = sum_q + in_data_i.rx_byte;
                count_d = count_q + 2'd1;
              end else begin
                phase_d = uref_pkg::PH_IDLE;
                count_d = '0;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Job generation
  always_comb begin
    push_o       = 1'b0;
    job_o.kind   = uref_pkg::JOB_REPORT;
    job_o.tx_bytes = '0;
    job_o.status = uref_pkg::ST_OK;
    job_o.raw    = '0;
    if (accept) begin
      unique case (in_data_i.req_type)
        uref_pkg::REQ_WRITE: begin
          push_o         = 1'b1;
          job_o.kind     = uref_pkg::JOB_WRITE;
          job_o.tx_bytes = {~wsum, in_data_i.write_value[7:0],
                            in_data_i.write_value[15:8], cmd_wr, cfg_i.frame_head};
        end
        uref_pkg::REQ_READ: begin
          push_o         = 1'b1;
          job_o.kind     = uref_pkg::JOB_READ;
          job_o.tx_bytes = {24'h0, cmd_rd, cfg_i.frame_head};
        end
        uref_pkg::REQ_RXBYTE: begin
          unique case (phase_q)
            uref_pkg::PH_ACK: begin
              push_o       = 1'b1;
              job_o.status = (in_data_i.rx_byte == cfg_i.ack_value) ?
                             uref_pkg::ST_OK : uref_pkg::ST_NACK;
            end
            uref_pkg::PH_READ: begin
              if (count_q == uref_pkg::READ_DATA_BYTES) begin
                push_o = 1'b1;
                if (chk_ok) begin
                  job_o.raw = shift_q;
                end else begin
                  job_o.status = uref_pkg::ST_CHKSUM;
                end
              end
            end
            default: begin
              push_o       = 1'b1;
              job_o.status = uref_pkg::ST_UNEXP;
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= uref_pkg::PH_IDLE;
      count_q <= '0;
      sum_q   <= '0;
      shift_q <= '0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      sum_q   <= sum_d;
      shift_q <= shift_d;
    end
  end

  // A write request always leaves the engine waiting for an ack
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.req_type == uref_pkg::REQ_WRITE |=> phase_q == uref_pkg::PH_ACK)
    else $error("write request did not enter ack phase");

  // Data bytes are only counted while a read is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd0 |-> phase_q == uref_pkg::PH_READ)
    else $error("byte count set outside read phase");

endmodule

>>> rtl/uref_fifo.sv
`timescale 1ns / 1ps
// Job queue between front and back end, DEPTH entries of job_t.
// Depends on uref_pkg.
module uref_fifo #(
  parameter int DEPTH = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  uref_pkg::job_t push_data_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output uref_pkg::job_t pop_data_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  uref_pkg::job_t mem_q [DEPTH];
  logic [PW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  count_q, count_d;
  logic           do_push, do_pop;

  assign full_o     = count_q == CW'(DEPTH);
  assign valid_o    = count_q != '0;
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  // Advance pointers with wrap and track fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage holds no control state
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // The front end never pushes into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i && full_o))
    else $error("push into full job queue");

  // Fill level stays in range
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CW'(DEPTH))
    else $error("job queue count out of range");

endmodule

>>> rtl/uref_back.sv
`timescale 1ns / 1ps
// Back end: expands queued jobs into result transactions behind an
// output register. Depends on uref_pkg.
module uref_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  uref_pkg::job_t    job_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output uref_pkg::out_item_t out_data_o
);

  uref_pkg::job_t      cur_q, cur_d;
  logic                cur_valid_q, cur_valid_d;
  logic [2:0]          idx_q, idx_d;
  logic                out_valid_q, out_valid_d;
  uref_pkg::out_item_t out_q, out_d;

  logic       load, at_last;
  logic [2:0] last_idx;

  // Last item index of the current job
  always_comb begin
    unique case (cur_q.kind)
      uref_pkg::JOB_WRITE: last_idx = uref_pkg::LAST_IDX_WRITE;
      uref_pkg::JOB_READ:  last_idx = uref_pkg::LAST_IDX_READ;
      default:             last_idx = uref_pkg::LAST_IDX_REPORT;
    endcase
  end

  assign load    = cur_valid_q && (!out_valid_q || !out_stall_i);
  assign at_last = idx_q == last_idx;
  assign pop_o   = job_valid_i && (!cur_valid_q || (load && at_last));

  // Pick up the next job or advance through the current one
  always_comb begin
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    if (pop_o) begin
      cur_d       = job_i;
      cur_valid_d = 1'b1;
      idx_d       = '0;
    end else if (load && at_last) begin
      cur_valid_d = 1'b0;
    end else if (load) begin
      idx_d = idx_q + 3'd1;
    end
  end

  // Form the next result transaction
  always_comb begin
    out_d.out_kind     = uref_pkg::KIND_TX;
    out_d.tx_byte      = cur_q.tx_bytes[idx_q];
    out_d.status       = uref_pkg::ST_OK;
    out_d.raw_value    = '0;
    out_d.signed_value = '0;
    out_d.last         = at_last;
    if (cur_q.kind == uref_pkg::JOB_REPORT) begin
      out_d.out_kind     = uref_pkg::KIND_REPORT;
      out_d.tx_byte      = '0;
      out_d.status       = cur_q.status;
      out_d.raw_value    = cur_q.raw;
      out_d.signed_value = $signed(cur_q.raw);
      out_d.last         = 1'b1;
    end
  end

  // Output register valid: load new, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Item index never runs past the end of its job
  assert property (@(posedge clk_i) disable iff (!rst_ni) cur_valid_q |-> idx_q <= last_idx)
    else $error("item index past end of job");

  // Every completion report closes its input's results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.out_kind == uref_pkg::KIND_REPORT |-> out_q.last)
    else $error("report without last flag");

endmodule

>>> rtl/uart_register_frame_engine.sv
`timescale 1ns / 1ps
// UART register frame engine, top level. An accepted input transaction passes
// through the job queue and the back end's current-job and output registers.
// The back end emits one result per cycle while the output is not stalled:
// 5 per write request, 2 per read, 1 per report; input stalls on a full queue.
// Reset (async, active low) clears phase, queue and output; config to defaults.
module uart_register_frame_engine #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  uref_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output uref_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [7:0]          cfg_data_i
);

  uref_pkg::cfg_t cfg_q, cfg_d;
  uref_pkg::job_t push_job, head_job;
  logic           push, full, job_valid, pop;

  // Configuration register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        uref_pkg::CFG_FRAME_HEAD:   cfg_d.frame_head   = cfg_data_i;
        uref_pkg::CFG_ACK_VALUE:    cfg_d.ack_value    = cfg_data_i;
        uref_pkg::CFG_ADDRESS_MASK: cfg_d.address_mask = cfg_data_i;
        uref_pkg::CFG_WRITE_FLAG:   cfg_d.write_flag   = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_head   <= uref_pkg::FRAME_HEAD_RST;
      cfg_q.ack_value    <= uref_pkg::ACK_VALUE_RST;
      cfg_q.address_mask <= uref_pkg::ADDRESS_MASK_RST;
      cfg_q.write_flag   <= uref_pkg::WRITE_FLAG_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  uref_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg_q),
    .full_i     (full),
    .push_o     (push),
    .job_o      (push_job)
  );

  uref_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .valid_o     (job_valid),
    .pop_i       (pop),
    .pop_data_o  (head_job)
  );

  uref_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for uart_register_frame_engine: write and read frames,
// acks, checksums, aborts and stray bytes, under random idling and back-pressure.
// Depends on uref_pkg and the engine RTL only.
module tb_top;

  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_OFF_CYCLES = 120;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  uref_pkg::in_item_t  in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  uref_pkg::out_item_t out_data_o;
  logic                cfg_we_i;
  logic [1:0]          cfg_idx_i;
  logic [7:0]          cfg_data_i;

  // Frame engine predictor state and configuration
  uref_pkg::phase_e    eng_phase;
  logic [2:0]          eng_count;
  logic [7:0]          eng_sum;
  logic [23:0]         eng_shift;
  uref_pkg::cfg_t      eng_cfg;
  uref_pkg::out_item_t expected_results[$];

  int tx_idle_pct;
  int rx_idle_pct;
  int hold_cycles_req;
  int rx_hold_left;
  int items_sent;
  int results_checked;
  int cfg_sets;
  int fail_count;

  uart_register_frame_engine dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Generate the clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // End the run if it hangs
  initial begin
    #5_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  // Queue one expected result
  function automatic void push_result(uref_pkg::kind_e kind, logic [7:0] tx,
                                      uref_pkg::status_e st, logic [23:0] raw,
                                      logic last);
    uref_pkg::out_item_t r;
    r.out_kind     = kind;
    r.tx_byte      = tx;
    r.status       = st;
    r.raw_value    = raw;
    r.signed_value = raw;
    r.last         = last;
    expected_results.push_back(r);
  endfunction

  // Predict the results of one accepted transaction and advance the state
  function automatic void predict_frame_results(uref_pkg::in_item_t it);
    logic [7:0] cmd;
    logic [7:0] sum;
    cmd = '0;
    sum = '0;
    case (it.req_type)
      uref_pkg::REQ_WRITE: begin
        cmd = (it.target_addr & eng_cfg.address_mask) | eng_cfg.write_flag;
        sum = eng_cfg.frame_head + cmd + it.write_value[15:8] + it.write_value[7:0];
        push_result(uref_pkg::KIND_TX, eng_cfg.frame_head, uref_pkg::ST_OK, '0, 1'b0);
        push_result(uref_pkg::KIND_TX, cmd, uref_pkg::ST_OK, '0, 1'b0);
        push_result(uref_pkg::KIND_TX, it.write_value[15:8], uref_pkg::ST_OK, '0, 1'b0);
        push_result(uref_pkg::KIND_TX, it.write_value[7:0], uref_pkg::ST_OK, '0, 1'b0);
        push_result(uref_pkg::KIND_TX, ~sum, uref_pkg::ST_OK, '0, 1'b1);
        eng_phase = uref_pkg::PH_ACK;
        eng_count = '0;
        eng_sum   = sum;
        eng_shift = '0;
      end
      uref_pkg::REQ_READ: begin
        cmd = it.target_addr & eng_cfg.address_mask;
        push_result(uref_pkg::KIND_TX, eng_cfg.frame_head, uref_pkg::ST_OK, '0, 1'b0);
        push_result(uref_pkg::KIND_TX, cmd, uref_pkg::ST_OK, '0, 1'b1);
        eng_phase = uref_pkg::PH_READ;
        eng_count = '0;
        eng_sum   = eng_cfg.frame_head + cmd;
        eng_shift = '0;
      end
      uref_pkg::REQ_RXBYTE: begin
        if (eng_phase == uref_pkg::PH_ACK) begin
          push_result(uref_pkg::KIND_REPORT, '0,
                      (it.rx_byte == eng_cfg.ack_value) ? uref_pkg::ST_OK
                                                        : uref_pkg::ST_NACK,
                      '0, 1'b1);
          eng_phase = uref_pkg::PH_IDLE;
          eng_count = '0;
        end else if (eng_phase == uref_pkg::PH_READ) begin
          if (eng_count < uref_pkg::READ_DATA_BYTES) begin
            eng_shift = {eng_shift[15:0], it.rx_byte};
            eng_sum   = eng_sum + it.rx_byte;
            eng_count = eng_count + 3'd1;
          end else begin
            eng_phase = uref_pkg::PH_IDLE;
            eng_count = '0;
            if (~eng_sum != it.rx_byte) begin
              push_result(uref_pkg::KIND_REPORT, '0, uref_pkg::ST_CHKSUM, '0, 1'b1);
            end else begin
              push_result(uref_pkg::KIND_REPORT, '0, uref_pkg::ST_OK, eng_shift, 1'b1);
            end
          end
        end else begin
          push_result(uref_pkg::KIND_REPORT, '0, uref_pkg::ST_UNEXP, '0, 1'b1);
        end
      end
      default: begin
        // unused request code: drop it
      end
    endcase
  endfunction

  function automatic uref_pkg::in_item_t make_item(uref_pkg::req_e req, logic [7:0] addr,
                                                   logic [15:0] val, logic [7:0] rx);
    uref_pkg::in_item_t it;
    it.req_type    = req;
    it.target_addr = addr;
    it.write_value = val;
    it.rx_byte     = rx;
    return it;
  endfunction

  // Received byte with random don't-care fields
  function automatic uref_pkg::in_item_t rx_item(logic [7:0] rx);
    return make_item(uref_pkg::REQ_RXBYTE, 8'($urandom_range(255)),
                     16'($urandom_range(65535)), rx);
  endfunction

  function automatic logic [7:0] random_byte_or_extreme();
    case ($urandom_range(3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic uref_pkg::cfg_t random_cfg();
    uref_pkg::cfg_t c;
    c.frame_head   = random_byte_or_extreme();
    c.ack_value    = random_byte_or_extreme();
    c.address_mask = random_byte_or_extreme();
    c.write_flag   = random_byte_or_extreme();
    return c;
  endfunction

  // Offer one transaction, idling at random first, and predict on acceptance
  task automatic send_item(uref_pkg::in_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_frame_results(it);
    if (it.req_type inside {uref_pkg::REQ_WRITE, uref_pkg::REQ_READ,
                            uref_pkg::REQ_RXBYTE}) items_sent++;
  endtask

  // Drop valid and wait until every expected result has come out
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write all four registers back to back
  task automatic apply_config(uref_pkg::cfg_t c);
    logic [7:0] vals [4];
    vals[uref_pkg::CFG_FRAME_HEAD]   = c.frame_head;
    vals[uref_pkg::CFG_ACK_VALUE]    = c.ack_value;
    vals[uref_pkg::CFG_ADDRESS_MASK] = c.address_mask;
    vals[uref_pkg::CFG_WRITE_FLAG]   = c.write_flag;
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= 2'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    eng_cfg = c;
    cfg_sets++;
  endtask

  // Write frame followed by a good or a bad ack
  task automatic do_write(logic [7:0] addr, logic [15:0] val, bit good_ack);
    logic [7:0] ack;
    ack = good_ack ? eng_cfg.ack_value : eng_cfg.ack_value ^ 8'($urandom_range(1, 255));
    send_item(make_item(uref_pkg::REQ_WRITE, addr, val, 8'($urandom_range(255))));
    send_item(rx_item(ack));
  endtask

  // Read frame, three data bytes and a good or a bad checksum
  task automatic do_read(logic [7:0] addr, logic [23:0] data, bit good_chk);
    logic [7:0] chk;
    send_item(make_item(uref_pkg::REQ_READ, addr, 16'($urandom_range(65535)),
                        8'($urandom_range(255))));
    send_item(rx_item(data[23:16]));
    send_item(rx_item(data[15:8]));
    send_item(rx_item(data[7:0]));
    chk = ~eng_sum;
    if (!good_chk) chk = chk ^ 8'($urandom_range(1, 255));
    send_item(rx_item(chk));
  endtask

  // Directed cases under the reset configuration
  task automatic test_directed();
    send_item(rx_item(8'h00));
    send_item(rx_item(8'hFF));
    do_write(8'hFF, 16'hFFFF, 1'b1);
    do_write(8'h00, 16'h0000, 1'b0);
    do_read(8'hFF, 24'h800001, 1'b1);
    do_read(8'h00, 24'h7FFFFF, 1'b0);
    // abort a pending read with a new write
    send_item(make_item(uref_pkg::REQ_READ, 8'h55, 16'h0000, 8'h00));
    send_item(rx_item(8'h12));
    do_write(8'hAA, 16'h1234, 1'b1);
    // unused request code
    send_item(make_item(uref_pkg::req_e'(2'd3), 8'hFF, 16'hFFFF, 8'hFF));
    do_read(8'h01, 24'hFFFFFF, 1'b1);
  endtask

  // Extreme register settings
  task automatic test_config_extremes();
    apply_config('{8'h00, 8'h00, 8'h00, 8'h00});
    do_write(8'hFF, 16'hFFFF, 1'b1);
    do_read(8'hFF, 24'h000000, 1'b1);
    apply_config('{8'hFF, 8'hFF, 8'hFF, 8'hFF});
    do_write(8'h00, 16'h8001, 1'b1);
    // abort a pending write with a read
    send_item(make_item(uref_pkg::REQ_WRITE, 8'h3C, 16'hA55A, 8'h00));
    do_read(8'h80, 24'hFEDCBA, 1'b1);
  endtask

  // Mostly well-formed frames with random content, plus noise
  task automatic test_random_traffic(int n_items, int tx_pct, int rx_pct);
    int start;
    int pick;
    apply_config(random_cfg());
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    start = items_sent;
    while (items_sent - start < n_items) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        do_write(8'($urandom_range(255)), 16'($urandom_range(65535)),
                 $urandom_range(3) != 0);
      end else if (pick < 70) begin
        do_read(8'($urandom_range(255)), 24'($urandom_range(24'hFFFFFF)),
                $urandom_range(3) != 0);
      end else if (pick < 95) begin
        send_item(make_item(uref_pkg::req_e'($urandom_range(2)), 8'($urandom_range(255)),
                            16'($urandom_range(65535)), 8'($urandom_range(255))));
      end else begin
        send_item(make_item(uref_pkg::req_e'(2'd3), 8'($urandom_range(255)),
                            16'($urandom_range(65535)), 8'($urandom_range(255))));
      end
    end
  endtask

  // Hold off the receiver while writes keep coming, so the input stalls
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_cycles_req = HOLD_OFF_CYCLES;
    for (int i = 0; i < 6; i++) begin
      do_write(8'($urandom_range(255)), 16'($urandom_range(65535)), 1'b1);
    end
  endtask

  // Drive output stall: random idling, or a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_cycles_req > 0) begin
      rx_hold_left    = hold_cycles_req;
      hold_cycles_req = 0;
    end
    if (rx_hold_left > 0) begin
      out_stall_i <= 1'b1;
      rx_hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin : check_results
    uref_pkg::out_item_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction %h", out_data_o);
        fail_count++;
      end else begin
        exp_r = expected_results.pop_front();
        results_checked++;
        if (out_data_o.out_kind !== exp_r.out_kind) begin
          $error("out_kind expected %0d actual %0d", exp_r.out_kind, out_data_o.out_kind);
          fail_count++;
        end
        if (out_data_o.tx_byte !== exp_r.tx_byte) begin
          $error("tx_byte expected %h actual %h", exp_r.tx_byte, out_data_o.tx_byte);
          fail_count++;
        end
        if (out_data_o.status !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, out_data_o.status);
          fail_count++;
        end
        if (out_data_o.raw_value !== exp_r.raw_value) begin
          $error("raw_value expected %h actual %h", exp_r.raw_value, out_data_o.raw_value);
          fail_count++;
        end
        if (out_data_o.signed_value !== exp_r.signed_value) begin
          $error("signed_value expected %0d actual %0d",
                 exp_r.signed_value, out_data_o.signed_value);
          fail_count++;
        end
        if (out_data_o.last !== exp_r.last) begin
          $error("last expected %0d actual %0d", exp_r.last, out_data_o.last);
          fail_count++;
        end
      end
    end
  end

  // Main sequence
  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    in_data_i       = '0;
    out_stall_i     = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_data_i      = '0;
    tx_idle_pct     = 0;
    rx_idle_pct     = 0;
    hold_cycles_req = 0;
    rx_hold_left    = 0;
    items_sent      = 0;
    results_checked = 0;
    cfg_sets        = 0;
    fail_count      = 0;
    eng_phase       = uref_pkg::PH_IDLE;
    eng_count       = '0;
    eng_sum         = '0;
    eng_shift       = '0;
    eng_cfg         = '{uref_pkg::FRAME_HEAD_RST, uref_pkg::ACK_VALUE_RST,
                        uref_pkg::ADDRESS_MASK_RST, uref_pkg::WRITE_FLAG_RST};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_config_extremes();
    test_random_traffic(20, 29, 88);
    test_random_traffic(20, 88, 29);
    test_random_traffic(20, 0, 0);
    test_backpressure();
    wait_idle();

    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      fail_count++;
    end
    $display("Covered %0d input transactions and %0d result transactions",
             items_sent, results_checked);
    $display("across %0d register settings, with idling and a long output hold-off",
             cfg_sets);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

>>> uart_register_frame_engine.f
rtl/uref_pkg.sv
rtl/uref_front.sv
rtl/uref_fifo.sv
rtl/uref_back.sv
rtl/uart_register_frame_engine.sv
sim/tb_top.sv
